[design/svt_pkg.sv]
// Package with the shared types and constants of the shape vote tracker.
`timescale 1ns / 1ps
package svt_pkg;
   localparam int SHAPE_COUNT = 4;
   localparam int ATTR_COUNT  = 8;
   localparam logic [30:0] PLANE_HEIGHT_RESET = 31'd13107;
   localparam logic [1:0] SHAPE_PLANE    = 2'd0;
   localparam logic [1:0] SHAPE_SPHERE   = 2'd1;
   localparam logic [1:0] SHAPE_CONE     = 2'd2;
   localparam logic [1:0] SHAPE_CYLINDER = 2'd3;

   typedef struct packed {
      logic        start;
      logic [32:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [32:0] quotient;
   } div_rsp_type;
endpackage

[design/svt_divider.sv]
// Restoring divider, one quotient bit a cycle, signed dividend, positive divisor.
`timescale 1ns / 1ps
module svt_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  svt_pkg::div_req_type req,
   output svt_pkg::div_rsp_type rsp
);
   logic        busy_ff, busy_in;
   logic [5:0]  count_ff, count_in;
   logic [32:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [33:0] trial;
   logic [32:0] shifted;

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      shifted  = {rem_ff[31:0], quo_ff[32]};
      trial    = {1'b0, shifted} - {2'b00, den_ff};
      if (req.start) begin
         busy_in  = 1'b1;
         count_in = 6'd0;
         neg_in   = req.dividend[32];
         quo_in   = req.dividend[32] ? (33'd0 - req.dividend) : req.dividend;
         rem_in   = 33'd0;
         den_in   = req.divisor;
      end else if (busy_ff) begin
         if (!trial[33]) begin
            rem_in = trial[32:0];
            quo_in = {quo_ff[31:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[31:0], 1'b0};
         end
         count_in = count_ff + 6'd1;
         if (count_ff == 6'd32) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (neg_ff) quo_in = 33'd0 - quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      neg_ff   <= neg_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");
   assert property (@(posedge clock) disable iff (reset) req.start |=> busy_ff)
      else $error("divider did not start");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> count_ff <= 6'd32)
      else $error("divider count overrun");
endmodule

[design/shape_vote_running_mean_tracker_unit.sv]
// Top level of the shape vote running mean tracker.
`timescale 1ns / 1ps
// One item at a time. After reset a clearing pass over all SLOT_COUNT*4*8 mean
// entries (512 at the defaults) zeroes the vote and mean memories before any
// item is taken. An item of a known shape runs its eight running-mean divisions
// through one bit-serial divider, each with a read-modify-write of the mean
// memory; an unknown shape skips the vote and the divisions, and an out-of-range
// slot goes straight to the output with zero means. A result waits in the output
// register and the next item is taken once it has gone.
module shape_vote_running_mean_tracker_unit #(
   parameter int SLOT_COUNT = 16,
   parameter int VOTE_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [30:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_slot_index,
   input  logic [15:0]        req_object_id,
   input  logic [2:0]         req_shape_code,
   input  logic [7:0]         req_color_code,
   input  logic signed [31:0] req_centroid_x,
   input  logic signed [31:0] req_centroid_y,
   input  logic signed [31:0] req_centroid_z,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   input  logic signed [31:0] req_radius_in,
   input  logic signed [31:0] req_height_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_out_object_id,
   output logic [1:0]         rsp_winning_shape,
   output logic [7:0]         rsp_out_color_code,
   output logic signed [31:0] rsp_mean_centroid_x,
   output logic signed [31:0] rsp_mean_centroid_y,
   output logic signed [31:0] rsp_mean_centroid_z,
   output logic signed [31:0] rsp_mean_axis_x,
   output logic signed [31:0] rsp_mean_axis_y,
   output logic signed [31:0] rsp_mean_axis_z,
   output logic signed [31:0] rsp_mean_radius,
   output logic signed [31:0] rsp_mean_height
);
   localparam int SLOT_BITS  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int VOTE_DEPTH = SLOT_COUNT * svt_pkg::SHAPE_COUNT;
   localparam int MEAN_DEPTH = VOTE_DEPTH * svt_pkg::ATTR_COUNT;
   localparam int VA_BITS    = SLOT_BITS + 2;
   localparam int MA_BITS    = SLOT_BITS + 5;
   localparam int CLR_BITS   = MA_BITS + 1;
   localparam logic [VOTE_WIDTH-1:0] VOTE_MAX = {VOTE_WIDTH{1'b1}};

   typedef enum logic [11:0] {
      ST_CLEAR  = 12'b000000000001,
      ST_IDLE   = 12'b000000000010,
      ST_VREAD  = 12'b000000000100,
      ST_VWAIT  = 12'b000000001000,
      ST_VOTE   = 12'b000000010000,
      ST_MREAD  = 12'b000000100000,
      ST_DIV    = 12'b000001000000,
      ST_MWRITE = 12'b000010000000,
      ST_WREAD  = 12'b000100000000,
      ST_WPICK  = 12'b001000000000,
      ST_OREAD  = 12'b010000000000,
      ST_OUT    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   logic [VOTE_WIDTH-1:0] vote_mem [VOTE_DEPTH];
   logic [31:0]           mean_mem [MEAN_DEPTH];

   logic [30:0] height_cfg_ff;
   logic [CLR_BITS-1:0] clr_ff, clr_in;
   logic [3:0]  slot_ff;
   logic [2:0]  shape_ff;
   logic [15:0] id_ff;
   logic [7:0]  color_ff;
   logic [31:0] sample_ff [svt_pkg::ATTR_COUNT];
   logic [2:0]  attr_ff, attr_in;
   logic [1:0]  vidx_ff, vidx_in;
   logic [VOTE_WIDTH-1:0] n_ff, n_in;
   logic [VOTE_WIDTH-1:0] best_ff, best_in;
   logic [1:0]  win_ff, win_in;
   logic [31:0] res_ff [svt_pkg::ATTR_COUNT];
   logic        rsp_valid_ff;
   logic        div_run_ff;

   logic                 v_we, m_we;
   logic [VA_BITS-1:0]   v_addr;
   logic [MA_BITS-1:0]   m_addr;
   logic [VOTE_WIDTH-1:0] v_wdata, v_rdata_ff;
   logic [31:0]          m_wdata, m_rdata_ff;
   logic                 in_range;
   logic [SLOT_BITS-1:0] slot_idx;
   logic                 accept;
   svt_pkg::div_req_type div_req;
   svt_pkg::div_rsp_type div_rsp;
   logic [32:0]          mean_new;

   assign in_range  = {28'd0, slot_ff} < 32'(SLOT_COUNT);
   assign slot_idx  = SLOT_BITS'(slot_ff);
   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign mean_new  = {m_rdata_ff[31], m_rdata_ff} + div_rsp.quotient;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      attr_in  = attr_ff;
      vidx_in  = vidx_ff;
      n_in     = n_ff;
      best_in  = best_ff;
      win_in   = win_ff;
      v_we     = 1'b0;
      m_we     = 1'b0;
      v_addr   = {slot_idx, shape_ff[1:0]};
      m_addr   = {slot_idx, shape_ff[1:0], attr_ff};
      v_wdata  = n_ff;
      m_wdata  = mean_new[31:0];
      div_req.start    = 1'b0;
      div_req.dividend = {sample_ff[attr_ff][31], sample_ff[attr_ff]}
                         - {m_rdata_ff[31], m_rdata_ff};
      div_req.divisor  = 32'(n_ff);
      case (state_ff)
         ST_CLEAR: begin
            m_we    = 1'b1;
            m_addr  = clr_ff[MA_BITS-1:0];
            m_wdata = 32'd0;
            v_we    = 1'b1;
            v_addr  = clr_ff[VA_BITS-1:0];
            v_wdata = '0;
            clr_in  = clr_ff + CLR_BITS'(1);
            if (clr_ff == CLR_BITS'(MEAN_DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_VREAD;
         end
         ST_VREAD: begin
            if (!in_range) begin
               win_in   = svt_pkg::SHAPE_PLANE;
               state_in = ST_OUT;
            end else if (shape_ff[2]) begin
               vidx_in  = 2'd0;
               best_in  = '0;
               win_in   = svt_pkg::SHAPE_PLANE;
               state_in = ST_WREAD;
            end else begin
               state_in = ST_VWAIT;
            end
         end
         ST_VWAIT: state_in = ST_VOTE;
         ST_VOTE: begin
            n_in     = (v_rdata_ff == VOTE_MAX) ? v_rdata_ff : v_rdata_ff + 1'b1;
            v_we     = 1'b1;
            v_wdata  = n_in;
            attr_in  = 3'd0;
            state_in = ST_MREAD;
         end
         ST_MREAD: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!div_run_ff) div_req.start = 1'b1;
            if (div_rsp.done) state_in = ST_MWRITE;
         end
         ST_MWRITE: begin
            m_we    = 1'b1;
            attr_in = attr_ff + 3'd1;
            if (attr_ff == 3'd7) begin
               vidx_in  = 2'd0;
               best_in  = '0;
               win_in   = svt_pkg::SHAPE_PLANE;
               state_in = ST_WREAD;
            end else begin
               state_in = ST_MREAD;
            end
         end
         ST_WREAD: begin
            v_addr   = {slot_idx, vidx_ff};
            state_in = ST_WPICK;
         end
         ST_WPICK: begin
            if (v_rdata_ff > best_ff) begin
               best_in = v_rdata_ff;
               win_in  = vidx_ff;
            end
            vidx_in = vidx_ff + 2'd1;
            if (vidx_ff == 2'd3) begin
               attr_in  = 3'd0;
               state_in = ST_OREAD;
            end else begin
               state_in = ST_WREAD;
            end
         end
         ST_OREAD: begin
            m_addr  = {slot_idx, win_ff, attr_ff};
            attr_in = attr_ff + 3'd1;
            if (attr_ff == 3'd7) state_in = ST_OUT;
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (v_we) vote_mem[v_addr] <= v_wdata;
      v_rdata_ff <= vote_mem[v_addr];
      if (m_we) mean_mem[m_addr] <= m_wdata;
      m_rdata_ff <= mean_mem[m_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         height_cfg_ff <= svt_pkg::PLANE_HEIGHT_RESET;
         rsp_valid_ff  <= 1'b0;
         div_run_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         div_run_ff <= (state_ff == ST_DIV);
         if (csr_write_enable) height_cfg_ff <= csr_write_data;
         if (state_ff == ST_OUT) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      attr_ff <= attr_in;
      vidx_ff <= vidx_in;
      n_ff    <= n_in;
      best_ff <= best_in;
      win_ff  <= win_in;
      if (accept) begin
         slot_ff      <= req_slot_index;
         shape_ff     <= req_shape_code;
         id_ff        <= req_object_id;
         color_ff     <= req_color_code;
         sample_ff[0] <= req_centroid_x;
         sample_ff[1] <= req_centroid_y;
         sample_ff[2] <= req_centroid_z;
         sample_ff[3] <= (req_shape_code < 3'd2) ? 32'd0 : req_axis_x;
         sample_ff[4] <= (req_shape_code < 3'd2) ? 32'd0 : req_axis_y;
         sample_ff[5] <= (req_shape_code < 3'd2) ? 32'd0 : req_axis_z;
         sample_ff[6] <= (req_shape_code == 3'd0) ? 32'd0 : req_radius_in;
         sample_ff[7] <= (req_shape_code == 3'd0) ? {1'b0, height_cfg_ff} :
                         (req_shape_code == 3'd1) ? 32'd0 : req_height_in;
      end
      if (state_ff == ST_VREAD && !in_range) begin
         for (int i = 0; i < svt_pkg::ATTR_COUNT; i++) res_ff[i] <= 32'd0;
      end
      if (state_ff == ST_OUT && in_range) res_ff[7] <= m_rdata_ff;
      if (state_ff == ST_OREAD && attr_ff != 3'd0) res_ff[attr_ff - 3'd1] <= m_rdata_ff;
   end

   svt_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_object_id   = id_ff;
   assign rsp_winning_shape   = win_ff;
   assign rsp_out_color_code  = color_ff;
   assign rsp_mean_centroid_x = res_ff[0];
   assign rsp_mean_centroid_y = res_ff[1];
   assign rsp_mean_centroid_z = res_ff[2];
   assign rsp_mean_axis_x     = res_ff[3];
   assign rsp_mean_axis_y     = res_ff[4];
   assign rsp_mean_axis_z     = res_ff[5];
   assign rsp_mean_radius     = res_ff[6];
   assign rsp_mean_height     = res_ff[7];

   assert property (@(posedge clock) disable iff (reset) accept |=> state_ff == ST_VREAD)
      else $error("item accepted outside idle");
   assert property (@(posedge clock) disable iff (reset) state_ff == ST_OUT |=> rsp_valid_ff)
      else $error("result not presented");
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == ST_VOTE |-> n_in != '0)
      else $error("zero divisor");
   assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
endmodule

[bench/shape_vote_running_mean_tracker_unit_test.sv]
// Testbench for the shape vote tracker: directed and random items checked against a predictor.
`timescale 1ns / 1ps
module shape_vote_running_mean_tracker_unit_test;
   localparam int SLOTS    = 16;
   localparam int VOTE_TOP = 65535;

   typedef struct packed {
      logic [3:0]       slot;
      logic [15:0]      id;
      logic [2:0]       shape;
      logic [7:0]       color;
      logic [7:0][31:0] attr;
   } detection_type;

   typedef struct packed {
      logic [15:0]      id;
      logic [1:0]       shape;
      logic [7:0]       color;
      logic [7:0][31:0] mean;
   } track_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [30:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_slot_index = '0;
   logic [15:0] req_object_id = '0;
   logic [2:0] req_shape_code = '0;
   logic [7:0] req_color_code = '0;
   logic signed [31:0] req_centroid_x = '0, req_centroid_y = '0, req_centroid_z = '0;
   logic signed [31:0] req_axis_x = '0, req_axis_y = '0, req_axis_z = '0;
   logic signed [31:0] req_radius_in = '0, req_height_in = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_out_object_id;
   logic [1:0] rsp_winning_shape;
   logic [7:0] rsp_out_color_code;
   logic signed [31:0] rsp_mean_centroid_x, rsp_mean_centroid_y, rsp_mean_centroid_z;
   logic signed [31:0] rsp_mean_axis_x, rsp_mean_axis_y, rsp_mean_axis_z;
   logic signed [31:0] rsp_mean_radius, rsp_mean_height;

   logic [30:0] plane_height;
   int unsigned vote_tally [SLOTS][svt_pkg::SHAPE_COUNT];
   logic [31:0] shape_means [SLOTS][svt_pkg::SHAPE_COUNT][svt_pkg::ATTR_COUNT];
   track_type pending_tracks [$];
   int mismatch_count = 0;
   bit quiet = 0;
   int hold_request = 0;

   shape_vote_running_mean_tracker_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic track_type track_detection(detection_type d);
      longint sample [svt_pkg::ATTR_COUNT];
      longint old;
      longint n;
      track_type t;
      int win;
      int unsigned top;
      t.id = d.id;
      t.color = d.color;
      for (int a = 0; a < svt_pkg::ATTR_COUNT; a++) sample[a] = $signed(d.attr[a]);
      if (d.shape == 3'(svt_pkg::SHAPE_SPHERE)) begin
         sample[3] = 0; sample[4] = 0; sample[5] = 0; sample[7] = 0;
      end else if (d.shape == 3'(svt_pkg::SHAPE_PLANE)) begin
         sample[3] = 0; sample[4] = 0; sample[5] = 0; sample[6] = 0;
         sample[7] = longint'(plane_height);
      end
      if (d.shape < svt_pkg::SHAPE_COUNT) begin
         if (vote_tally[d.slot][d.shape] < VOTE_TOP) vote_tally[d.slot][d.shape]++;
         n = vote_tally[d.slot][d.shape];
         for (int a = 0; a < svt_pkg::ATTR_COUNT; a++) begin
            old = $signed(shape_means[d.slot][d.shape][a]);
            shape_means[d.slot][d.shape][a] = 32'(old + (sample[a] - old) / n);
         end
      end
      win = 0;
      top = 0;
      for (int s = 0; s < svt_pkg::SHAPE_COUNT; s++) begin
         if (vote_tally[d.slot][s] > top) begin
            top = vote_tally[d.slot][s];
            win = s;
         end
      end
      t.shape = 2'(win);
      for (int a = 0; a < svt_pkg::ATTR_COUNT; a++) t.mean[a] = shape_means[d.slot][win][a];
      return t;
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
         3: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
         default: return $urandom;
      endcase
   endfunction

   function automatic detection_type random_detection(int slot_span, int unknown_pct);
      detection_type d;
      d.slot = 4'($urandom_range(0, slot_span - 1));
      d.id = 16'($urandom);
      d.color = 8'($urandom);
      if ($urandom_range(1, 100) <= unknown_pct) d.shape = 3'($urandom_range(4, 7));
      else if ($urandom_range(0, 1)) d.shape = 3'(d.slot % 4);
      else d.shape = 3'($urandom_range(0, 3));
      for (int a = 0; a < svt_pkg::ATTR_COUNT; a++) d.attr[a] = random_word();
      return d;
   endfunction

   task automatic send_detection(detection_type d);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_slot_index <= d.slot;
      req_object_id <= d.id;
      req_shape_code <= d.shape;
      req_color_code <= d.color;
      req_centroid_x <= d.attr[0];
      req_centroid_y <= d.attr[1];
      req_centroid_z <= d.attr[2];
      req_axis_x <= d.attr[3];
      req_axis_y <= d.attr[4];
      req_axis_z <= d.attr[5];
      req_radius_in <= d.attr[6];
      req_height_in <= d.attr[7];
      do @(posedge clock); while (!req_ready);
      pending_tracks.insert(pending_tracks.size(), track_detection(d));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_tracks.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_plane_height(logic [30:0] value);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      plane_height = value;
      csr_write_enable <= 1'b0;
   endtask

   always begin
      int stall;
      track_type seen;
      track_type want;
      stall = quiet ? 0 : $urandom_range(0, 10);
      if (hold_request > 0) begin
         stall = hold_request;
         hold_request = 0;
      end
      if (stall > 0) begin
         rsp_ready <= 1'b0;
         repeat (stall) @(posedge clock);
      end
      rsp_ready <= 1'b1;
      do @(posedge clock); while (!(rsp_valid && !reset));
      seen = {rsp_out_object_id, rsp_winning_shape, rsp_out_color_code,
              rsp_mean_height, rsp_mean_radius, rsp_mean_axis_z, rsp_mean_axis_y,
              rsp_mean_axis_x, rsp_mean_centroid_z, rsp_mean_centroid_y,
              rsp_mean_centroid_x};
      if (pending_tracks.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10) $display("Unexpected item: %h", seen);
      end else begin
         want = pending_tracks.pop_front();
         if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Mismatch: id %h/%h shape %0d/%0d colour %h/%h",
                        want.id, seen.id, want.shape, seen.shape, want.color, seen.color);
               for (int a = 0; a < svt_pkg::ATTR_COUNT; a++)
                  $display("  mean %0d expected %h actual %h", a, want.mean[a], seen.mean[a]);
            end
         end
      end
   end

   task automatic test_unknown_on_empty_slot();
      detection_type d;
      for (int c = 4; c < 8; c++) begin
         d = random_detection(SLOTS, 0);
         d.slot = 4'(15 - c);
         d.shape = 3'(c);
         send_detection(d);
      end
   endtask

   task automatic test_each_shape_and_extremes();
      detection_type d;
      for (int s = 0; s < 4; s++) begin
         d = random_detection(SLOTS, 0);
         d.slot = 4'd1;
         d.shape = 3'(s);
         d.attr = {8{s[0] ? 32'h7FFF_FFFF : 32'h8000_0000}};
         send_detection(d);
         d.attr = {8{s[0] ? 32'h8000_0000 : 32'h7FFF_FFFF}};
         send_detection(d);
      end
      d.slot = 4'hF;
      d.id = 16'hFFFF;
      d.color = 8'hFF;
      d.shape = 3'(svt_pkg::SHAPE_CYLINDER);
      d.attr = {8{32'hFFFF_FFFF}};
      send_detection(d);
   endtask

   task automatic test_tie_break();
      detection_type d;
      logic [2:0] order [3] = '{3'(svt_pkg::SHAPE_SPHERE), 3'(svt_pkg::SHAPE_CONE),
                                3'(svt_pkg::SHAPE_PLANE)};
      for (int i = 0; i < 3; i++) begin
         d = random_detection(SLOTS, 0);
         d.slot = 4'd2;
         d.shape = order[i];
         send_detection(d);
      end
   endtask

   task automatic test_plane_height_settings();
      detection_type d;
      logic [30:0] settings [3] = '{31'd0, 31'h7FFF_FFFF, 31'($urandom)};
      foreach (settings[i]) begin
         write_plane_height(settings[i]);
         repeat (2) begin
            d = random_detection(SLOTS, 0);
            d.slot = 4'd3;
            d.shape = 3'(svt_pkg::SHAPE_PLANE);
            send_detection(d);
         end
      end
      write_plane_height(svt_pkg::PLANE_HEIGHT_RESET);
   endtask

   task automatic test_output_backpressure();
      wait_drained();
      hold_request = 3000;
      repeat (6) send_detection(random_detection(4, 10));
   endtask

   task automatic test_random_tracks();
      for (int i = 0; i < 900; i++) begin
         if (i % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (i == 450) begin
            quiet = 0;
            write_plane_height(31'($urandom));
         end
         send_detection(random_detection(i < 450 ? 4 : SLOTS, 8));
      end
      quiet = 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      plane_height = svt_pkg::PLANE_HEIGHT_RESET;
      foreach (vote_tally[s, k]) vote_tally[s][k] = 0;
      foreach (shape_means[s, k, a]) shape_means[s][k][a] = '0;
      test_unknown_on_empty_slot();
      test_each_shape_and_extremes();
      test_tie_break();
      test_plane_height_settings();
      test_output_backpressure();
      test_random_tracks();
      wait_drained();
      repeat (400) @(posedge clock);
      if (mismatch_count == 0 && pending_tracks.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
